[rtl/core/fnvh_pkg.sv]
// types and constants shared by the 256-bit fnv-1a style header hash core (prime 0x163 only)
// no dependencies
package fnvh_pkg;

    typedef logic [63:0] lane_t;
    typedef logic [8:0]  carry_t;

    localparam int LANE_W  = 64;
    localparam int CARRY_W = 9;
    localparam int PROD_W  = LANE_W + CARRY_W;

    // 0x163 = 256 + 64 + 32 + 2 + 1
    localparam carry_t PRIME = 9'h163;

    // offset basis, lane 0 most significant
    localparam lane_t BASIS_0 = 64'hdd268dbcaae09484;
    localparam lane_t BASIS_1 = 64'hdb9f6aae0c414b41;
    localparam lane_t BASIS_2 = 64'h217224d10d3b261d;
    localparam lane_t BASIS_3 = 64'hc4ef15815a2ef065;

    localparam logic [1:0] REG_VERSION        = 2'd0;
    localparam logic [1:0] REG_EPOCH          = 2'd1;
    localparam logic [1:0] REG_MESSAGE_LENGTH = 2'd2;

    localparam logic [1:0] LAST_LANE = 2'd3;

endpackage

[rtl/core/fnvh_mac.sv]
// shared multiply-accumulate unit: one 64-bit lane times the prime plus carry-in
// depends on fnvh_pkg
module fnvh_mac
    import fnvh_pkg::*;
(
    input  lane_t  lane_in,
    input  carry_t carry_in,
    output lane_t  lane_out,
    output carry_t carry_out
);

    logic [PROD_W-1:0] prod;

    assign prod      = PROD_W'(lane_in) * PROD_W'(PRIME) + PROD_W'(carry_in);
    assign lane_out  = prod[LANE_W-1:0];
    assign carry_out = prod[PROD_W-1:LANE_W];

endmodule

[rtl/core/fnv1a_256_header_hash_top.sv]
// 256-bit fnv-1a style header hash core, top level; the multiplier is 0x163, not the full fnv-256 prime
// flow: each data byte is latched, then takes 4 lane multiplies through fnvh_mac, and in_stall stays
// high until they are done; the first byte of a message is preceded by the 16-byte header fold
// output: after the last byte the 4 hash words follow, one per cycle while out_stall is low; the
// input stays stalled through the hand-over, longer while a previous hash is still draining
// reset: hash at offset basis, header pending, version 0, epoch 0, message length 1
module fnv1a_256_header_hash_top
    import fnvh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_word,
    output logic [1:0]  word_index,
    output logic        last_word,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_DATA,
        ST_DONE
    } state_t;

    state_t        state_reg;
    logic [31:0]   abi_reg;
    logic [63:0]   epoch_reg;
    logic [31:0]   length_reg;
    lane_t         hash_reg [4];
    logic          hdr_pending_reg;
    logic [31:0]   seen_reg;
    logic          final_reg;
    logic [7:0]    data_reg;
    logic [3:0]    byte_cnt_reg;
    logic [1:0]    step_reg;
    carry_t        carry_reg;
    lane_t         obuf_reg [4];
    logic          out_valid_reg;
    logic [1:0]    idx_reg;

    logic [127:0]  hdr_vec;
    logic [127:0]  hdr_shift;
    logic [7:0]    cur_byte;
    lane_t         mac_in;
    lane_t         mac_out;
    carry_t        mac_carry;
    logic [32:0]   seen_inc;
    logic          in_take;
    logic          out_take;

    assign hdr_vec   = {abi_reg, epoch_reg, length_reg};
    // header byte k sits at bit 8*(15-k)
    assign hdr_shift = hdr_vec >> {~byte_cnt_reg, 3'b000};
    assign cur_byte  = (state_reg == ST_HDR) ? hdr_shift[7:0] : data_reg;
    // byte is folded into the low lane before its first multiply
    assign mac_in    = hash_reg[3] ^ ((step_reg == 2'd0) ? {56'd0, cur_byte} : '0);
    assign seen_inc  = {1'b0, seen_reg} + 33'd1;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    assign out_valid  = out_valid_reg;
    assign hash_word  = obuf_reg[0];
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == LAST_LANE);

    fnvh_mac u_mac (
        .lane_in   (mac_in),
        .carry_in  (carry_reg),
        .lane_out  (mac_out),
        .carry_out (mac_carry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            abi_reg         <= '0;
            epoch_reg       <= '0;
            length_reg      <= 32'd1;
            hash_reg[0]     <= BASIS_0;
            hash_reg[1]     <= BASIS_1;
            hash_reg[2]     <= BASIS_2;
            hash_reg[3]     <= BASIS_3;
            hdr_pending_reg <= 1'b1;
            seen_reg        <= '0;
            final_reg       <= 1'b0;
            data_reg        <= '0;
            byte_cnt_reg    <= '0;
            step_reg        <= '0;
            carry_reg       <= '0;
            obuf_reg[0]     <= '0;
            obuf_reg[1]     <= '0;
            obuf_reg[2]     <= '0;
            obuf_reg[3]     <= '0;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_VERSION:        abi_reg    <= cfg_data[31:0];
                    REG_EPOCH:          epoch_reg  <= cfg_data;
                    REG_MESSAGE_LENGTH: length_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end

            if (out_take)
            begin
                obuf_reg[0] <= obuf_reg[1];
                obuf_reg[1] <= obuf_reg[2];
                obuf_reg[2] <= obuf_reg[3];
                idx_reg     <= idx_reg + 2'd1;
                if (idx_reg == LAST_LANE)
                begin
                    out_valid_reg <= 1'b0;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        data_reg     <= data_byte;
                        byte_cnt_reg <= '0;
                        step_reg     <= '0;
                        carry_reg    <= '0;
                        // zero length behaves like one
                        if (seen_inc >= {1'b0, length_reg})
                        begin
                            final_reg <= 1'b1;
                            seen_reg  <= '0;
                        end
                        else
                        begin
                            final_reg <= 1'b0;
                            seen_reg  <= seen_inc[31:0];
                        end
                        state_reg <= hdr_pending_reg ? ST_HDR : ST_DATA;
                    end
                end
                ST_HDR, ST_DATA:
                begin
                    // lanes rotate so the unit always works on position 3
                    hash_reg[0] <= mac_out;
                    hash_reg[1] <= hash_reg[0];
                    hash_reg[2] <= hash_reg[1];
                    hash_reg[3] <= hash_reg[2];
                    step_reg    <= step_reg + 2'd1;
                    if (step_reg == LAST_LANE)
                    begin
                        carry_reg <= '0;
                        if (state_reg == ST_HDR)
                        begin
                            byte_cnt_reg <= byte_cnt_reg + 4'd1;
                            if (byte_cnt_reg == 4'd15)
                            begin
                                hdr_pending_reg <= 1'b0;
                                state_reg       <= ST_DATA;
                            end
                        end
                        else
                        begin
                            state_reg <= final_reg ? ST_DONE : ST_IDLE;
                        end
                    end
                    else
                    begin
                        carry_reg <= mac_carry;
                    end
                end
                ST_DONE:
                begin
                    // wait for the previous hash to drain, then hand over and re-arm
                    if (!out_valid_reg)
                    begin
                        obuf_reg[0]     <= hash_reg[0];
                        obuf_reg[1]     <= hash_reg[1];
                        obuf_reg[2]     <= hash_reg[2];
                        obuf_reg[3]     <= hash_reg[3];
                        out_valid_reg   <= 1'b1;
                        idx_reg         <= '0;
                        hash_reg[0]     <= BASIS_0;
                        hash_reg[1]     <= BASIS_1;
                        hash_reg[2]     <= BASIS_2;
                        hash_reg[3]     <= BASIS_3;
                        hdr_pending_reg <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
